[rtl/hoe_pkg.sv]
// Package for the hash ordinal encoder: table sizing, field widths and controller states.
package hoe_pkg;

  // CAPACITY must be a power of two: the start slot is the low key bits
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned ORD_W    = 11;
  localparam int unsigned ENTRY_W  = KEY_W + ORD_W;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_CHECK = 3'b100
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ORD_W-1:0] ordinal;
  } entry_t;

endpackage

[rtl/hash_ordinal_encoder_core.sv]
// Hash ordinal encoder: open-addressed key/ordinal table with linear probing in one RAM.
//
// Input stream s_axis: tdata carries the 64-bit key, tlast the batch end flag.
// Output stream m_axis: one transaction per input transaction, in order. tdata holds
// the ordinal and the entry total, tuser the inserted and table full flags, tlast
// the copied batch end flag.
// After reset the controller sweeps the table RAM to zero, one slot a cycle, over
// all CAPACITY slots (1024); s_axis_tready stays low during the sweep.
// CAPACITY is a power of two, so the start slot is the low key bits. An item
// probes its slots in turn, one RAM read per cycle (the RAM port sets the probe
// rate), and the next item is accepted only once its final probe is done; that
// final probe waits while the output register is full. The result is registered.
// A key of zero ends at its first check, and the slot it reads is ignored.
// The output register lets a new item be accepted while a result waits; if the
// receiver stalls, the controller holds its last probe until the register frees up.
module hash_ordinal_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] key
  input  logic        s_axis_tlast,   // batch_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [10:0] ordinal, [21:11] entry_total, [23:22] zero
  output logic [1:0]  m_axis_tuser,   // [0] inserted, [1] table_full
  output logic        m_axis_tlast    // batch_end_out
);

  localparam int unsigned IW = hoe_pkg::IDX_W;
  localparam int unsigned OW = hoe_pkg::ORD_W;
  localparam int unsigned KW = hoe_pkg::KEY_W;
  localparam logic [IW-1:0] IDX_LAST = IW'(hoe_pkg::CAPACITY - 1);

  // table RAM
  hoe_pkg::entry_t mem_q [hoe_pkg::CAPACITY];
  hoe_pkg::entry_t rd_q;
  hoe_pkg::entry_t wr_data;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic            rd_en;
  logic [IW-1:0]   rd_addr;

  hoe_pkg::state_e        state_q, state_d;
  logic [IW-1:0]          idx_q, idx_d;
  logic [IW-1:0]          probe_q, probe_d;
  logic [OW-1:0]          cnt_q, cnt_d;
  logic [KW-1:0]          key_q, key_d;
  logic                   last_q, last_d;
  logic                   zero_q, zero_d;

  logic                   ovalid_q, ovalid_d;
  logic [OW-1:0]          oord_q, oord_d;
  logic [OW-1:0]          otot_q, otot_d;
  logic                   oins_q, oins_d;
  logic                   ofull_q, ofull_d;
  logic                   olast_q, olast_d;

  logic                   in_fire;
  logic                   out_free;
  logic                   hit;
  logic                   empty;
  logic [IW-1:0]          idx_next;
  logic                   ins_fire;

  assign s_axis_tready = (state_q == hoe_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ovalid_q || m_axis_tready;
  assign hit           = (rd_q.key == key_q);
  assign empty         = (rd_q.key == '0);
  assign idx_next      = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    probe_d  = probe_q;
    cnt_d    = cnt_q;
    key_d    = key_q;
    last_d   = last_q;
    zero_d   = zero_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    oord_d   = oord_q;
    otot_d   = otot_q;
    oins_d   = oins_q;
    ofull_d  = ofull_q;
    olast_d  = olast_q;
    wr_en    = 1'b0;
    wr_addr  = idx_q;
    wr_data  = '0;
    rd_en    = 1'b0;
    rd_addr  = idx_q;
    ins_fire = 1'b0;

    case (state_q)
      hoe_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
        idx_d = idx_next;
        if (idx_q == IDX_LAST) begin
          state_d = hoe_pkg::ST_IDLE;
        end
      end
      hoe_pkg::ST_IDLE: begin
        if (in_fire) begin
          key_d   = s_axis_tdata;
          last_d  = s_axis_tlast;
          zero_d  = (s_axis_tdata == '0);
          probe_d = '0;
          idx_d   = s_axis_tdata[IW-1:0];
          rd_en   = 1'b1;
          rd_addr = s_axis_tdata[IW-1:0];
          state_d = hoe_pkg::ST_CHECK;
        end
      end
      hoe_pkg::ST_CHECK: begin
        if (zero_q || hit || empty || probe_q == IDX_LAST) begin
          // final probe: hold until the output register can take the result
          if (out_free) begin
            ovalid_d = 1'b1;
            olast_d  = last_q;
            oins_d   = 1'b0;
            ofull_d  = 1'b0;
            oord_d   = '0;
            otot_d   = cnt_q;
            if (zero_q) begin
              oord_d = '0;
            end else if (hit) begin
              oord_d = rd_q.ordinal;
            end else if (empty) begin
              ins_fire        = 1'b1;
              cnt_d           = cnt_q + 1'b1;
              wr_en           = 1'b1;
              wr_data.key     = key_q;
              wr_data.ordinal = cnt_q + 1'b1;
              oord_d          = cnt_q + 1'b1;
              otot_d          = cnt_q + 1'b1;
              oins_d          = 1'b1;
            end else begin
              ofull_d = 1'b1;
            end
            state_d = hoe_pkg::ST_IDLE;
          end
        end else begin
          // occupied by another key: advance to the next slot
          idx_d   = idx_next;
          probe_d = probe_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = idx_next;
        end
      end
      default: begin
        state_d = hoe_pkg::ST_CLEAR;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hoe_pkg::ST_CLEAR;
      idx_q    <= '0;
      probe_q  <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      probe_q  <= probe_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    last_q  <= last_d;
    zero_q  <= zero_d;
    oord_q  <= oord_d;
    otot_q  <= otot_d;
    oins_q  <= oins_d;
    ofull_q <= ofull_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {2'b00, otot_q, oord_q};
  assign m_axis_tuser  = {ofull_q, oins_q};
  assign m_axis_tlast  = olast_q;

  // the entry count moves only on an insertion
  a_cnt_only_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> $past(ins_fire))
    else $error("entry count changed without an insertion");

  // a fresh insertion reports the new total as its ordinal
  a_insert_ordinal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && oins_q) |-> (oord_q == otot_q && !ofull_q))
    else $error("inserted result with inconsistent ordinal");

  // a full-table result carries no ordinal
  a_full_no_ordinal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ofull_q) |-> (oord_q == '0))
    else $error("table full result with nonzero ordinal");

  // no RAM write while an item is accepted
  a_no_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !wr_en)
    else $error("table write during input acceptance");

  // a result is only loaded into a free output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready && state_q == hoe_pkg::ST_CHECK) |=> $stable(otot_q))
    else $error("pending result overwritten");

endmodule

[sim/testbench.sv]
// Testbench for the hash ordinal encoder: stream stimulus, table predictor and result checker.
module testbench;

  localparam int unsigned CAPACITY     = hoe_pkg::CAPACITY;
  localparam int unsigned KEY_W        = hoe_pkg::KEY_W;
  localparam int unsigned ORD_W        = hoe_pkg::ORD_W;
  localparam int unsigned IDX_W        = hoe_pkg::IDX_W;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = CAPACITY + 64;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 200;

  typedef struct packed {
    logic [1:0]       pad;
    logic [ORD_W-1:0] entry_total;
    logic [ORD_W-1:0] ordinal;
    logic             table_full;
    logic             inserted;
    logic             batch_end;
  } enc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [63:0] key
  logic        s_axis_tlast;   // batch_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [10:0] ordinal, [21:11] entry_total, [23:22] zero
  logic [1:0]  m_axis_tuser;   // [0] inserted, [1] table_full
  logic        m_axis_tlast;   // batch_end_out

  // Shadow copy of the hash table
  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [ORD_W-1:0] ord_mem [CAPACITY];
  logic [ORD_W-1:0] entry_count;

  enc_result_t      pending_results [$];
  logic [KEY_W-1:0] known_keys [$];
  int unsigned      mismatches;
  int unsigned      cycle_count;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  int unsigned      hold_requests;

  hash_ordinal_encoder_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      key_mem[i] = '0;
      ord_mem[i] = '0;
    end
    entry_count = '0;
  end

  // Probe from key mod CAPACITY; hit returns the stored ordinal, empty slot takes the key
  function automatic enc_result_t encode_key(input logic [KEY_W-1:0] key, input logic last);
    enc_result_t res;
    int unsigned slot;
    int unsigned probe;
    bit          done;
    res = '0;
    res.batch_end = last;
    if (key != '0) begin
      slot = int'(key % CAPACITY);
      done = 1'b0;
      for (probe = 0; probe < CAPACITY && !done; probe++) begin
        if (key_mem[slot] == key) begin
          res.ordinal = ord_mem[slot];
          done = 1'b1;
        end else if (key_mem[slot] == '0) begin
          entry_count   = entry_count + 1'b1;
          key_mem[slot] = key;
          ord_mem[slot] = entry_count;
          res.ordinal   = entry_count;
          res.inserted  = 1'b1;
          done = 1'b1;
        end else begin
          slot = (slot + 1 == CAPACITY) ? 0 : slot + 1;
        end
      end
      res.table_full = !done;
    end
    res.entry_total = entry_count;
    return res;
  endfunction

  // Leave tvalid high after a transaction so back-to-back items need no second assignment
  task automatic send_key(input logic [KEY_W-1:0] key, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = key;
    s_axis_tlast  = last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(encode_key(key, last));
    if (key != '0) known_keys.push_back(key);
    @(negedge clk_i);
  endtask

  // Mix of fresh keys, repeats, zero keys and keys colliding with a stored slot
  task automatic send_random_item();
    logic [KEY_W-1:0] key;
    int unsigned      pick;
    pick = $urandom_range(99);
    key  = {$urandom, $urandom};
    if (pick >= 45 && pick < 75 && known_keys.size() != 0)
      key = known_keys[$urandom_range(known_keys.size() - 1)];
    else if (pick >= 75 && pick < 85)
      key = '0;
    else if (pick >= 85 && known_keys.size() != 0)
      key[IDX_W-1:0] = known_keys[$urandom_range(known_keys.size() - 1)][IDX_W-1:0];
    send_key(key, 1'($urandom_range(1)));
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_key(64'h0, 1'b0);
    send_key(64'h1, 1'b1);
    send_key(64'h1, 1'b0);
    send_key({KEY_W{1'b1}}, 1'b0);
    send_key(64'h8000_0000_0000_0000, 1'b1);
    // slot 0 taken: walks past slot 1 into slot 2
    send_key(64'h400, 1'b0);
    // slot 1023 taken: wraps around to slot 3
    send_key(64'h7FF, 1'b0);
    send_key(64'h400, 1'b1);
    send_key(64'h7FF, 1'b0);
    send_key({KEY_W{1'b1}}, 1'b1);
    send_key(64'h0, 1'b1);
    send_key(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_key(64'h5555_5555_5555_5555, 1'b1);
    send_key(64'h8000_0000_0000_0000, 1'b0);
  endtask

  task automatic test_random();
    int unsigned idle_pcts  [4] = '{0, 61, 0, 12};
    int unsigned stall_pcts [4] = '{0, 0, 61, 12};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pcts[p];
      recv_stall_pct = stall_pcts[p];
      repeat (RANDOM_ITEMS / 4) send_random_item();
    end
  endtask

  // Receiver holds off while items keep coming, so the input side must stall
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    repeat (40) send_random_item();
  endtask

  // Give every remaining empty slot a key that lands on it directly
  task automatic test_fill();
    logic [KEY_W-1:0] key;
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    while (entry_count != CAPACITY) begin
      for (int unsigned slot = 0; slot < CAPACITY; slot++) begin
        if (key_mem[slot] == '0) begin
          key = {$urandom, $urandom};
          key[IDX_W]       = 1'b1;
          key[IDX_W-1:0]   = IDX_W'(slot);
          send_key(key, 1'($urandom_range(1)));
        end
      end
    end
  endtask

  task automatic test_overflow();
    int unsigned last_slot;
    send_idle_pct  = 61;
    recv_stall_pct = 61;
    last_slot = 0;
    for (int unsigned slot = 0; slot < CAPACITY; slot++)
      if (ord_mem[slot] == ORD_W'(CAPACITY)) last_slot = slot;
    send_key({$urandom, $urandom} | 64'h1, 1'b0);
    send_key(64'h0, 1'b1);
    send_key(key_mem[last_slot], 1'b0);
    send_key({$urandom, $urandom} | 64'h8000_0000_0000_0000, 1'b1);
    send_key(key_mem[0], 1'b1);
    send_key(key_mem[CAPACITY-1], 1'b0);
    send_key({KEY_W{1'b1}} ^ 64'h3FF, 1'b0);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left     = 0;
    holds_served  = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    enc_result_t got;
    enc_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{pad:         m_axis_tdata[23:22],
              entry_total: m_axis_tdata[21:11],
              ordinal:     m_axis_tdata[10:0],
              table_full:  m_axis_tuser[1],
              inserted:    m_axis_tuser[0],
              batch_end:   m_axis_tlast};
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result ord=%0d total=%0d ins=%0b full=%0b last=%0b",
                 $time, got.ordinal, got.entry_total, got.inserted, got.table_full,
                 got.batch_end);
      end else begin
        exp_res = pending_results.pop_front();
        if (got !== exp_res) begin
          mismatches++;
          $display("%0t: expected ord=%0d total=%0d ins=%0b full=%0b last=%0b pad=%0h",
                   $time, exp_res.ordinal, exp_res.entry_total, exp_res.inserted,
                   exp_res.table_full, exp_res.batch_end, exp_res.pad);
          $display("%0t: actual   ord=%0d total=%0d ins=%0b full=%0b last=%0b pad=%0h",
                   $time, got.ordinal, got.entry_total, got.inserted, got.table_full,
                   got.batch_end, got.pad);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    mismatches     = 0;
    hold_requests  = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    test_fill();
    test_overflow();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
